// ===== rtl/best_fit_band_allocator_macros.svh =====
// Assertion macros shared by the allocator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BEST_FIT_BAND_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BAND_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BFBA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bfba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

    // Default number of bands that the hardware supports.
    localparam int NUM_BANDS_DEF = 64;

    // Fixed field widths of the channels.
    localparam int MASK_W  = 64;
    localparam int REQ_W   = 8;
    localparam int BANDS_W = 7;
    localparam int START_W = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Reset value of the band count register.
    localparam logic [BANDS_W-1:0] BANDS_IN_USE_RST = 7'd64;

    // Item operation codes.
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Band status codes.
    localparam logic [STAT_W-1:0] ST_UNUSED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHARED    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXCLUSIVE = 2'd2;

    // Controls from the sequencer to the run tracker.
    typedef struct packed {
        logic clear;
        logic visit;
        logic usable;
        logic weigh;
    } bfba_trk_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bfba_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface bfba_item_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [bfba_pkg::MASK_W-1:0]  occupied_mask;
    logic                         use_reuse;
    logic [bfba_pkg::MASK_W-1:0]  conflict_mask;
    logic [bfba_pkg::REQ_W-1:0]   request_blocks;

    modport source (
        output valid, opcode, occupied_mask, use_reuse, conflict_mask, request_blocks,
        input  ready
    );
    modport sink (
        input  valid, opcode, occupied_mask, use_reuse, conflict_mask, request_blocks,
        output ready
    );
endinterface

// Result channel.
interface bfba_result_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [bfba_pkg::START_W-1:0]  start_band;
    logic [bfba_pkg::COUNT_W-1:0]  block_count;
    logic                          whole_request;

    modport source (
        output valid, granted, start_band, block_count, whole_request,
        input  ready
    );
    modport sink (
        input  valid, granted, start_band, block_count, whole_request,
        output ready
    );
endinterface

// Configuration write channel for the band count register.
interface bfba_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bfba_pkg::BANDS_W-1:0]  bands_in_use;

    modport source (
        output valid, bands_in_use,
        input  ready
    );
    modport sink (
        input  valid, bands_in_use,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/bfba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module bfba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bfba_msb_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Finds the highest set bit of a mask by shifting it out one bit per cycle.
// The result is ready with the done pulse.
module bfba_msb_finder #(
    parameter int NUM_BANDS = bfba_pkg::NUM_BANDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [NUM_BANDS-1:0]          mask,
    output logic                               done,
    output logic [$clog2(NUM_BANDS)-1:0]       msb
);

    localparam int IDX_W = $clog2(NUM_BANDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BANDS - 1);

    logic [NUM_BANDS-1:0] sr_reg,   sr_next;
    logic [IDX_W-1:0]     idx_reg,  idx_next;
    logic [IDX_W-1:0]     msb_reg,  msb_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Shift the mask down and remember the position of the last set bit seen.
    always_comb
    begin
        sr_next   = sr_reg;
        idx_next  = idx_reg;
        msb_next  = msb_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sr_next   = mask;
            idx_next  = '0;
            msb_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sr_reg[0])
            begin
                msb_next = idx_reg;
            end
            sr_next  = sr_reg >> 1;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            msb_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            msb_reg  <= msb_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // The shifted mask is payload.
    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    assign done = done_reg;
    assign msb  = msb_reg;

endmodule

`default_nettype wire

// ===== rtl/bfba_run_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tracks the current run of usable bands and the best run so far, one band a cycle.
// A run is preferred when it is strictly longer than the request and shorter than
// the best such run; with no such run, the longest run wins. Ties keep the first.
module bfba_run_tracker #(
    parameter int NUM_BANDS = bfba_pkg::NUM_BANDS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bfba_pkg::bfba_trk_ctl_t            ctl,
    input  wire logic [$clog2(NUM_BANDS)-1:0]       band,
    input  wire logic [bfba_pkg::REQ_W-1:0]         req,
    output logic      [$clog2(NUM_BANDS)-1:0]       best_start,
    output logic      [$clog2(NUM_BANDS+1)-1:0]     best_length
);

    localparam int IDX_W = $clog2(NUM_BANDS);
    localparam int CNT_W = $clog2(NUM_BANDS + 1);

    logic [IDX_W-1:0] best_start_reg, best_start_next;
    logic [CNT_W-1:0] best_len_reg,   best_len_next;
    logic             best_sat_reg,   best_sat_next;
    logic [IDX_W-1:0] run_start_reg,  run_start_next;
    logic [CNT_W-1:0] run_len_reg,    run_len_next;

    logic [IDX_W-1:0] w_start;
    logic [CNT_W-1:0] w_len;
    logic             w_sat;

    // Best run after weighing the current run against it.
    always_comb
    begin
        w_start = best_start_reg;
        w_len   = best_len_reg;
        w_sat   = best_sat_reg;
        if (bfba_pkg::REQ_W'(run_len_reg) > req)
        begin
            if (!best_sat_reg || best_len_reg > run_len_reg)
            begin
                w_sat   = 1'b1;
                w_start = run_start_reg;
                w_len   = run_len_reg;
            end
        end
        else if (!best_sat_reg && best_len_reg < run_len_reg)
        begin
            w_start = run_start_reg;
            w_len   = run_len_reg;
        end
    end

    // Run and best-run update for one visited band.
    always_comb
    begin
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_sat_next   = best_sat_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        if (ctl.clear)
        begin
            best_start_next = '0;
            best_len_next   = '0;
            best_sat_next   = 1'b0;
            run_start_next  = '0;
            run_len_next    = '0;
        end
        else if (ctl.visit)
        begin
            if (!ctl.usable)
            begin
                if (run_len_reg != '0)
                begin
                    best_start_next = w_start;
                    best_len_next   = w_len;
                    best_sat_next   = w_sat;
                    run_start_next  = '0;
                    run_len_next    = '0;
                end
            end
            else
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = band;
                end
                run_len_next = run_len_reg + 1'b1;
            end
        end
        else if (ctl.weigh)
        begin
            best_start_next = w_start;
            best_len_next   = w_len;
            best_sat_next   = w_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_start_reg <= '0;
            best_len_reg   <= '0;
            best_sat_reg   <= 1'b0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
        end
        else
        begin
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            best_sat_reg   <= best_sat_next;
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
        end
    end

    assign best_start  = best_start_reg;
    assign best_length = best_len_reg;

endmodule

`default_nettype wire

// ===== rtl/best_fit_band_allocator.sv =====
// Request item: accepted in idle; the scan state reads each band in turn; the flush, weigh and
// grant states close the scan and compute the grant; the mark state marks each granted band in
// turn; the done state hands over the result once the output register is free. The band scan and
// the marking sweep both go through the status RAM ports. New-frame item: bit-serial search for
// the highest pre-occupied band. One item is in work at a time.
// Reset is asynchronous, active low: all bands unused, no pre-occupied bands, 64 bands.
`timescale 1ns / 1ps
`default_nettype none

`include "best_fit_band_allocator_macros.svh"

module best_fit_band_allocator #(
    parameter int NUM_BANDS = bfba_pkg::NUM_BANDS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bfba_item_if.sink     item,
    bfba_result_if.source result,
    bfba_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(NUM_BANDS);
    localparam int CNT_W = $clog2(NUM_BANDS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FRAME = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_FLUSH = 8'b0000_1000,
        S_WEIGH = 8'b0001_0000,
        S_GRANT = 8'b0010_0000,
        S_MARK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } bfba_state_t;

    bfba_state_t state_reg, state_next;

    logic [bfba_pkg::BANDS_W-1:0] bands_reg, bands_next;
    logic [NUM_BANDS-1:0]         pre_reg, pre_next;
    logic [IDX_W-1:0]             up_start_reg, up_start_next;
    logic [NUM_BANDS-1:0]         vld_reg, vld_next;

    logic                         reuse_reg, reuse_next;
    logic [bfba_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [NUM_BANDS-1:0]         conf_reg, conf_next;

    logic [IDX_W-1:0]             addr_reg, addr_next;
    logic [CNT_W-1:0]             left_reg, left_next;
    logic                         p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]             p_band_reg, p_band_next;

    logic [IDX_W-1:0]             mark_addr_reg, mark_addr_next;
    logic [CNT_W-1:0]             mark_left_reg, mark_left_next;

    logic                         res_granted_reg, res_granted_next;
    logic [IDX_W-1:0]             res_low_reg, res_low_next;
    logic [CNT_W-1:0]             res_count_reg, res_count_next;
    logic                         res_whole_reg, res_whole_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_granted_reg;
    logic [bfba_pkg::START_W-1:0]   out_start_reg;
    logic [bfba_pkg::COUNT_W-1:0]   out_count_reg;
    logic                           out_whole_reg;

    logic                           item_acc;
    logic                           out_load;
    logic [CNT_W-1:0]               n_eff;
    logic [CNT_W-1:0]               n_dec;
    logic [CNT_W-1:0]               up_left;
    logic [CNT_W-1:0]               first_left;

    logic                           msb_start;
    logic                           msb_done;
    logic [IDX_W-1:0]               msb_idx;

    bfba_pkg::bfba_trk_ctl_t        trk_ctl;
    logic [IDX_W-1:0]               best_start;
    logic [CNT_W-1:0]               best_len;

    logic [bfba_pkg::STAT_W-1:0]    ram_q;
    logic [bfba_pkg::STAT_W-1:0]    band_st;
    logic                           band_usable;

    logic [CNT_W-1:0]               grant_cnt;
    logic [CNT_W-1:0]               grant_low_full;
    logic [IDX_W-1:0]               grant_low;

    // Handshakes.
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign item_acc   = item.valid && item.ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Effective band count and the scan lengths that follow from it.
    assign n_eff   = (bands_reg > bfba_pkg::BANDS_W'(NUM_BANDS)) ? CNT_W'(NUM_BANDS)
                                                                 : CNT_W'(bands_reg);
    assign n_dec   = n_eff - 1'b1;
    assign up_left = (CNT_W'(up_start_reg) < n_eff) ? (n_eff - CNT_W'(up_start_reg)) : '0;
    assign first_left = item.use_reuse ? up_left : n_eff;

    // Band status memory; entries without a valid bit read as unused.
    bfba_ram #(
        .WIDTH (bfba_pkg::STAT_W),
        .DEPTH (NUM_BANDS)
    ) u_status_ram (
        .clk   (clk),
        .we    (state_reg == S_MARK),
        .waddr (mark_addr_reg),
        .wdata (reuse_reg ? bfba_pkg::ST_SHARED : bfba_pkg::ST_EXCLUSIVE),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    assign band_st = vld_reg[p_band_reg] ? ram_q : bfba_pkg::ST_UNUSED;

    // A band is usable when it is free for this kind of request.
    always_comb
    begin
        if (reuse_reg)
        begin
            band_usable = !(pre_reg[p_band_reg] || conf_reg[p_band_reg] ||
                            (band_st == bfba_pkg::ST_EXCLUSIVE));
        end
        else
        begin
            band_usable = !(pre_reg[p_band_reg] || (band_st != bfba_pkg::ST_UNUSED));
        end
    end

    // Highest pre-occupied band search for a new frame.
    bfba_msb_finder #(
        .NUM_BANDS (NUM_BANDS)
    ) u_msb_finder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (msb_start),
        .mask  (item.occupied_mask[NUM_BANDS-1:0]),
        .done  (msb_done),
        .msb   (msb_idx)
    );

    // Run tracker controls.
    always_comb
    begin
        trk_ctl.clear  = item_acc && (item.opcode == bfba_pkg::OP_REQUEST);
        trk_ctl.visit  = p_valid_reg;
        trk_ctl.usable = band_usable;
        trk_ctl.weigh  = (state_reg == S_WEIGH);
    end

    bfba_run_tracker #(
        .NUM_BANDS (NUM_BANDS)
    ) u_run_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (trk_ctl),
        .band        (p_band_reg),
        .req         (req_reg),
        .best_start  (best_start),
        .best_length (best_len)
    );

    // Grant size and lowest band of the granted part of the best run.
    assign grant_cnt      = (bfba_pkg::REQ_W'(best_len) < req_reg) ? best_len
                                                                   : CNT_W'(req_reg);
    assign grant_low_full = CNT_W'(best_start) + 1'b1 - grant_cnt;
    assign grant_low      = reuse_reg ? best_start : grant_low_full[IDX_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        bands_next       = bands_reg;
        pre_next         = pre_reg;
        up_start_next    = up_start_reg;
        vld_next         = vld_reg;
        reuse_next       = reuse_reg;
        req_next         = req_reg;
        conf_next        = conf_reg;
        addr_next        = addr_reg;
        left_next        = left_reg;
        p_valid_next     = 1'b0;
        p_band_next      = p_band_reg;
        mark_addr_next   = mark_addr_reg;
        mark_left_next   = mark_left_reg;
        res_granted_next = res_granted_reg;
        res_low_next     = res_low_reg;
        res_count_next   = res_count_reg;
        res_whole_next   = res_whole_reg;
        msb_start        = 1'b0;

        if (cfg.valid && cfg.ready)
        begin
            bands_next = cfg.bands_in_use;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    res_granted_next = 1'b0;
                    res_low_next     = '0;
                    res_count_next   = '0;
                    res_whole_next   = 1'b0;
                    if (item.opcode == bfba_pkg::OP_FRAME)
                    begin
                        pre_next   = item.occupied_mask[NUM_BANDS-1:0];
                        vld_next   = '0;
                        msb_start  = 1'b1;
                        state_next = S_FRAME;
                    end
                    else
                    begin
                        reuse_next = item.use_reuse;
                        req_next   = item.request_blocks;
                        conf_next  = item.conflict_mask[NUM_BANDS-1:0];
                        addr_next  = item.use_reuse ? up_start_reg : n_dec[IDX_W-1:0];
                        left_next  = first_left;
                        state_next = (first_left != '0) ? S_SCAN : S_WEIGH;
                    end
                end
            end
            S_FRAME:
            begin
                if (msb_done)
                begin
                    up_start_next = msb_idx;
                    state_next    = S_DONE;
                end
            end
            S_SCAN:
            begin
                // Issue one band read a cycle; the band is judged in the next cycle, when its read data returns.
                p_valid_next = 1'b1;
                p_band_next  = addr_reg;
                addr_next    = reuse_reg ? (addr_reg + 1'b1) : (addr_reg - 1'b1);
                left_next    = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_WEIGH;
            end
            S_WEIGH:
            begin
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                if ((req_reg == '0) || (best_len == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    res_granted_next = 1'b1;
                    res_low_next     = grant_low;
                    res_count_next   = grant_cnt;
                    res_whole_next   = (bfba_pkg::REQ_W'(grant_cnt) == req_reg);
                    mark_addr_next   = grant_low;
                    mark_left_next   = grant_cnt;
                    state_next       = S_MARK;
                end
            end
            S_MARK:
            begin
                // Mark one granted band a cycle.
                vld_next[mark_addr_reg] = 1'b1;
                mark_addr_next = mark_addr_reg + 1'b1;
                mark_left_next = mark_left_reg - 1'b1;
                if (mark_left_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register holds a result until the transfer completes.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bands_reg       <= bfba_pkg::BANDS_IN_USE_RST;
            pre_reg         <= '0;
            up_start_reg    <= '0;
            vld_reg         <= '0;
            left_reg        <= '0;
            p_valid_reg     <= 1'b0;
            mark_left_reg   <= '0;
            res_granted_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bands_reg       <= bands_next;
            pre_reg         <= pre_next;
            up_start_reg    <= up_start_next;
            vld_reg         <= vld_next;
            left_reg        <= left_next;
            p_valid_reg     <= p_valid_next;
            mark_left_reg   <= mark_left_next;
            res_granted_reg <= res_granted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        reuse_reg     <= reuse_next;
        req_reg       <= req_next;
        conf_reg      <= conf_next;
        addr_reg      <= addr_next;
        p_band_reg    <= p_band_next;
        mark_addr_reg <= mark_addr_next;
        res_low_reg   <= res_low_next;
        res_count_reg <= res_count_next;
        res_whole_reg <= res_whole_next;
        if (out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_start_reg   <= bfba_pkg::START_W'(res_low_reg);
            out_count_reg   <= bfba_pkg::COUNT_W'(res_count_reg);
            out_whole_reg   <= res_whole_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.granted       = out_granted_reg;
    assign result.start_band    = out_start_reg;
    assign result.block_count   = out_count_reg;
    assign result.whole_request = out_whole_reg;

    // A granted result carries a nonzero count that never exceeds the request.
    `BFBA_ASSERT_IMPLY(a_grant_count, (out_load && res_granted_reg),
        ((res_count_reg != '0) && (bfba_pkg::REQ_W'(res_count_reg) <= req_reg)),
        "granted count out of range")
    // A result waiting on a stalled output keeps the sequencer parked.
    `BFBA_ASSERT_NEXT(a_done_hold,
        ((state_reg == S_DONE) && out_valid_reg && !result.ready),
        (state_reg == S_DONE), "result overwritten while stalled")
    // Marking never runs with an exhausted band count.
    `BFBA_ASSERT_IMPLY(a_mark_left, (state_reg == S_MARK), (mark_left_reg != '0),
        "marking with no bands left")

endmodule

`default_nettype wire

// ===== bench/tb_best_fit_band_allocator.sv =====
`timescale 1ns / 1ps

module tb_best_fit_band_allocator;

    localparam int BANDS = bfba_pkg::NUM_BANDS_DEF;

    typedef struct packed {
        logic                          opcode;
        logic [bfba_pkg::MASK_W-1:0]   occupied_mask;
        logic                          use_reuse;
        logic [bfba_pkg::MASK_W-1:0]   conflict_mask;
        logic [bfba_pkg::REQ_W-1:0]    request_blocks;
    } alloc_item_t;

    typedef struct packed {
        logic                          granted;
        logic [bfba_pkg::START_W-1:0]  start_band;
        logic [bfba_pkg::COUNT_W-1:0]  block_count;
        logic                          whole_request;
    } alloc_result_t;

    typedef struct packed {
        alloc_item_t   item;
        logic          fixed;
        alloc_result_t res;
    } directed_row_t;

    localparam alloc_result_t NO_GRANT = '0;

    logic clk;
    logic rst_n;

    bfba_item_if   item_ch ();
    bfba_result_if res_ch ();
    bfba_cfg_if    cfg_ch ();

    best_fit_band_allocator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Shadow copy of the frame state and the band count register.
    logic [bfba_pkg::STAT_W-1:0]  band_state [BANDS];
    logic [bfba_pkg::MASK_W-1:0]  frame_taken;
    int                           reuse_floor;
    int                           bands_cfg;

    alloc_result_t      pending_grants [$];
    directed_row_t      directed_rows [$];
    int                 mismatch_count;
    bit                 hold_sink_req;
    bit                 steady_tail;

    int phase_bands [8] = '{1, 2, 37, 127, 0, 64, 13, 64};
    int phase_items [8] = '{150, 150, 250, 200, 30, 300, 250, 170};

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Computes the grant for one item and updates the shadow band state.
    function automatic alloc_result_t predict_grant(input alloc_item_t it);
        alloc_result_t res;
        int n, steps, i, k, b, req, count, low;
        int best_start, best_len, run_start, run_len;
        bit best_ok, usable;
        res = '0;
        if (it.opcode == bfba_pkg::OP_FRAME)
        begin
            for (b = 0; b < BANDS; b++)
                band_state[b] = bfba_pkg::ST_UNUSED;
            frame_taken = it.occupied_mask;
            reuse_floor = 0;
            for (b = 0; b < BANDS; b++)
                if (frame_taken[b])
                    reuse_floor = b;
            return res;
        end

        req = int'(it.request_blocks);
        n = (bands_cfg > BANDS) ? BANDS : bands_cfg;
        best_start = 0;
        best_len = 0;
        best_ok = 1'b0;
        run_start = 0;
        run_len = 0;
        k = 0;
        if (it.use_reuse)
            steps = (n > reuse_floor) ? n - reuse_floor : 0;
        else
            steps = n;

        // One extra pass with an unusable band closes the last run.
        for (i = 0; i <= steps; i++)
        begin
            if (i == steps)
                usable = 1'b0;
            else if (it.use_reuse)
            begin
                k = reuse_floor + i;
                usable = !frame_taken[k] && band_state[k] != bfba_pkg::ST_EXCLUSIVE &&
                         !it.conflict_mask[k];
            end
            else
            begin
                k = n - 1 - i;
                usable = !frame_taken[k] && band_state[k] == bfba_pkg::ST_UNUSED;
            end

            if (usable)
            begin
                if (run_len == 0)
                    run_start = k;
                run_len++;
            end
            else if (run_len != 0)
            begin
                // Prefer the shortest run longer than the request, else the longest.
                if (run_len > req)
                begin
                    if (!best_ok || best_len > run_len)
                    begin
                        best_ok = 1'b1;
                        best_start = run_start;
                        best_len = run_len;
                    end
                end
                else if (!best_ok && best_len < run_len)
                begin
                    best_start = run_start;
                    best_len = run_len;
                end
                run_len = 0;
            end
        end

        if (req == 0 || best_len == 0)
            return res;

        count = (best_len < req) ? best_len : req;
        low = it.use_reuse ? best_start : best_start + 1 - count;
        for (b = low; b < low + count && b < BANDS; b++)
            band_state[b] = it.use_reuse ? bfba_pkg::ST_SHARED : bfba_pkg::ST_EXCLUSIVE;

        res.granted = 1'b1;
        res.start_band = low[bfba_pkg::START_W-1:0];
        res.block_count = count[bfba_pkg::COUNT_W-1:0];
        res.whole_request = (count == req);
        return res;
    endfunction

    function automatic directed_row_t make_row(input logic op, input logic [63:0] occ,
                                               input logic reuse, input logic [63:0] conf,
                                               input int req, input logic fixed,
                                               input alloc_result_t res);
        directed_row_t r;
        r.item.opcode = op;
        r.item.occupied_mask = occ;
        r.item.use_reuse = reuse;
        r.item.conflict_mask = conf;
        r.item.request_blocks = req[bfba_pkg::REQ_W-1:0];
        r.fixed = fixed;
        r.res = res;
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input directed_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Band masks: mostly sparse, with empty, full, dense and single-band cases.
    function automatic logic [63:0] pick_mask();
        logic [63:0] m;
        case ($urandom_range(0, 9))
            0: m = '0;
            1: m = '1;
            2: m = {$urandom, $urandom};
            3: m = 64'd1 << $urandom_range(0, 63);
            default: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return m;
    endfunction

    function automatic int pick_request();
        int r;
        case ($urandom_range(0, 9))
            0: r = 0;
            1: r = $urandom_range(0, 255);
            2: r = $urandom_range(17, 64);
            default: r = $urandom_range(1, 12);
        endcase
        return r;
    endfunction

    // Offers one item, waits for the transfer and records the expected grant.
    task automatic send_item(input alloc_item_t it, input logic fixed,
                             input alloc_result_t res);
        alloc_result_t predicted;
        if (!steady_tail && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= it.opcode;
        item_ch.occupied_mask  <= it.occupied_mask;
        item_ch.use_reuse      <= it.use_reuse;
        item_ch.conflict_mask  <= it.conflict_mask;
        item_ch.request_blocks <= it.request_blocks;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = predict_grant(it);
        pending_grants.insert(pending_grants.size(), fixed ? res : predicted);
    endtask

    // Stops offering items and waits until every expected grant has come back.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_bands(input int value);
        drain_results();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.bands_in_use <= value[bfba_pkg::BANDS_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        bands_cfg = int'(value[bfba_pkg::BANDS_W-1:0]);
    endtask

    // Frames followed by bursts of requests, with some malformed items mixed in.
    task automatic run_random(input int item_total);
        alloc_item_t it;
        int sent, burst, j;
        sent = 0;
        while (sent < item_total)
        begin
            it.opcode = bfba_pkg::OP_FRAME;
            it.occupied_mask = pick_mask();
            it.use_reuse = 1'($urandom_range(0, 1));
            it.conflict_mask = {$urandom, $urandom};
            it.request_blocks = bfba_pkg::REQ_W'($urandom_range(0, 255));
            send_item(it, 1'b0, NO_GRANT);
            sent++;
            burst = $urandom_range(2, 14);
            for (j = 0; j < burst && sent < item_total; j++)
            begin
                it.opcode = bfba_pkg::OP_REQUEST;
                it.occupied_mask = {$urandom, $urandom};
                it.use_reuse = 1'($urandom_range(0, 1));
                it.conflict_mask = pick_mask();
                it.request_blocks = bfba_pkg::REQ_W'(pick_request());
                if ($urandom_range(0, 9) == 0)
                begin
                    it.opcode = 1'($urandom_range(0, 1));
                    it.conflict_mask = {$urandom, $urandom};
                    it.request_blocks = bfba_pkg::REQ_W'($urandom_range(0, 255));
                end
                send_item(it, 1'b0, NO_GRANT);
                sent++;
            end
        end
    endtask

    // Result sink: random stall bursts, one long hold-off on request, none in the tail.
    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_sink_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_sink_req = 1'b0;
            end
            else if (steady_tail || $urandom_range(0, 3) != 0)
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    // Compare every result transfer against the oldest expected grant.
    always @(posedge clk)
    begin
        alloc_result_t got, want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.granted = res_ch.granted;
            got.start_band = res_ch.start_band;
            got.block_count = res_ch.block_count;
            got.whole_request = res_ch.whole_request;
            if (pending_grants.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: expected no result, actual granted=%0d start=%0d count=%0d whole=%0d",
                         $time, got.granted, got.start_band, got.block_count,
                         got.whole_request);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.granted !== want.granted || got.start_band !== want.start_band ||
                    got.block_count !== want.block_count ||
                    got.whole_request !== want.whole_request)
                begin
                    mismatch_count++;
                    $display("%0t: granted/start/count/whole expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                             $time, want.granted, want.start_band, want.block_count,
                             want.whole_request, got.granted, got.start_band,
                             got.block_count, got.whole_request);
                end
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int phase, i;
        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.opcode         <= bfba_pkg::OP_FRAME;
        item_ch.occupied_mask  <= '0;
        item_ch.use_reuse      <= 1'b0;
        item_ch.conflict_mask  <= '0;
        item_ch.request_blocks <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.bands_in_use    <= bfba_pkg::BANDS_IN_USE_RST;
        mismatch_count = 0;
        hold_sink_req = 1'b0;
        steady_tail = 1'b0;
        bands_cfg = int'(bfba_pkg::BANDS_IN_USE_RST);
        frame_taken = '0;
        reuse_floor = 0;
        for (i = 0; i < BANDS; i++)
            band_state[i] = bfba_pkg::ST_UNUSED;

        // Out of reset all bands are free; then empty, full and patterned frames.
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 0, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 4, 1'b1,
                         {1'b1, 6'd60, 7'd4, 1'b1}));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 3, 1'b1,
                         {1'b1, 6'd0, 7'd3, 1'b1}));
        add_row(make_row(bfba_pkg::OP_FRAME, '1, 1'b0, '0, 0, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 5, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 5, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_FRAME, '0, 1'b1, '1, 255, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '1, 1'b0, '1, 255, 1'b1,
                         {1'b1, 6'd0, 7'd64, 1'b0}));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 255, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_FRAME, 64'h8000_0000_0000_0001, 1'b0, '0, 0,
                         1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 1, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 62, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_FRAME, 64'h0000_0F00_00F0_0001, 1'b0, '0, 0,
                         1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 3, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 16, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, 64'h001C_0000_0000_0000, 2,
                         1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '1, 0, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '1, 8, 1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 30, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_FRAME, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, 0,
                         1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 1, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 1, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_FRAME, 64'h5555_5555_5555_5555, 1'b0, '0, 0,
                         1'b1, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b1, '0, 200, 1'b0, NO_GRANT));
        add_row(make_row(bfba_pkg::OP_REQUEST, '0, 1'b0, '0, 2, 1'b0, NO_GRANT));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[row_idx])
            send_item(directed_rows[row_idx].item, directed_rows[row_idx].fixed,
                      directed_rows[row_idx].res);

        // Random phases, each under its own band count.
        for (phase = 0; phase < 8; phase++)
        begin
            write_bands(phase_bands[phase]);
            if (phase == 0)
                hold_sink_req = 1'b1;
            if (phase == 7)
                steady_tail = 1'b1;
            run_random(phase_items[phase]);
        end

        drain_results();
        repeat (140) @(posedge clk);
        if (pending_grants.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_grants.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_best_fit_band_allocator: PASS");
        else
            $display("tb_best_fit_band_allocator: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #12_000_000;
        $display("tb_best_fit_band_allocator: FAIL");
        $finish;
    end

endmodule
